@@ rtl/ritoa_pkg.sv @@
// Shared constants, types and helper functions for the radix integer-to-ASCII converter.
package ritoa_pkg;

  // Field widths of the channels.
  localparam int unsigned ValueW = 64;
  localparam int unsigned RadixW = 6;
  localparam int unsigned CharW  = 7;
  localparam int unsigned CountW = 7;

  // Sizing of the conversion.
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned MAX_DIGITS = 64;

  // The divider retires this many dividend bits per cycle.
  localparam int unsigned STEP_BITS  = 8;
  localparam int unsigned NUM_CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned WORK_W     = NUM_CHUNKS * STEP_BITS;
  localparam int unsigned CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);
  localparam int unsigned FOUND_W    = $clog2(MAX_DIGITS + 1);

  // Radix limits and character codes.
  localparam logic [RadixW-1:0] RADIX_MIN    = 6'd2;
  localparam logic [RadixW-1:0] RADIX_MAX    = 6'd36;
  localparam logic [RadixW-1:0] DECIMAL_SPAN = 6'd10;
  localparam logic [CharW-1:0]  CHAR_ZERO    = 7'd48;
  localparam logic [CharW-1:0]  CHAR_LETTER_A = 7'd65;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [RadixW-1:0] radix_t;
  typedef logic [CharW-1:0]  char_t;
  typedef logic [CountW-1:0] count_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_EMIT
  } state_e;

  // Bring any radix code into the supported range.
  function automatic radix_t clamp_radix(radix_t raw);
    radix_t r;
    r = raw;
    if (r < RADIX_MIN) begin
      r = RADIX_MIN;
    end
    if (r > RADIX_MAX) begin
      r = RADIX_MAX;
    end
    return r;
  endfunction

  // Map a digit value of 0 to 35 onto '0'-'9' and 'A'-'Z'.
  function automatic char_t digit_to_ascii(radix_t d);
    char_t ch;
    if (d < DECIMAL_SPAN) begin
      ch = CHAR_ZERO + char_t'(d);
    end else begin
      ch = CHAR_LETTER_A + char_t'(d - DECIMAL_SPAN);
    end
    return ch;
  endfunction

endpackage

@@ rtl/ritoa_in_if.sv @@
// Input channel: a value and its radix under a valid/ready handshake.
interface ritoa_in_if;
  logic               valid;
  logic               ready;
  ritoa_pkg::value_t  value;
  ritoa_pkg::radix_t  radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

@@ rtl/ritoa_out_if.sv @@
// Output channel: one ASCII digit per item under a valid/ready handshake.
interface ritoa_out_if;
  logic               valid;
  logic               ready;
  ritoa_pkg::char_t   digit_char;
  ritoa_pkg::count_t  digit_count;
  logic               last_digit;

  modport source (output valid, output digit_char, output digit_count, output last_digit,
                  input ready);
  modport sink   (input valid, input digit_char, input digit_count, input last_digit,
                  output ready);
endinterface

@@ rtl/ritoa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module ritoa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/radix_integer_to_ascii_unit.sv @@
// Top level: converts an unsigned value to ASCII digits in a radix from 2 to 36.
// Each digit is one full pass of the shared 8-bit-per-cycle restoring divider over all NUM_CHUNKS chunks.
// One item is in flight at a time; the input is ready only while the sequencer idles.
// Digits come out one per cycle while the output is ready, most significant first, read back from the digit RAM.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle; the RAM is not cleared.
module radix_integer_to_ascii_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  ritoa_in_if.sink     in_i,
  ritoa_out_if.source  out_o
);

  ritoa_pkg::state_e                   state_q, state_d;
  logic [ritoa_pkg::WORK_W-1:0]        work_q, work_d;
  ritoa_pkg::radix_t                   radix_q, radix_d;
  ritoa_pkg::radix_t                   rem_q, rem_d;
  logic [ritoa_pkg::CHUNK_W-1:0]       chunk_q, chunk_d;
  logic [ritoa_pkg::FOUND_W-1:0]       found_q, found_d;
  logic [ritoa_pkg::IDX_W-1:0]         idx_q, idx_d;

  logic [ritoa_pkg::STEP_BITS-1:0]     chunk_bits;
  logic [ritoa_pkg::STEP_BITS-1:0]     quot_bits;
  ritoa_pkg::radix_t                   rem_next;
  logic [ritoa_pkg::WORK_W-1:0]        quot_next;
  logic                                last_chunk;
  logic                                div_done;
  logic                                in_fire;
  logic                                out_fire;
  logic                                ram_we;
  ritoa_pkg::radix_t                   ram_rdata;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  // Shared divider step: eight restoring-division bits of the running dividend.
  always_comb begin
    logic [ritoa_pkg::RadixW:0] trial;
    ritoa_pkg::radix_t          r;
    chunk_bits = work_q[ritoa_pkg::WORK_W-1 -: ritoa_pkg::STEP_BITS];
    quot_bits  = '0;
    r          = rem_q;
    for (int i = ritoa_pkg::STEP_BITS - 1; i >= 0; i--) begin
      trial = {r, chunk_bits[i]};
      if (trial >= {1'b0, radix_q}) begin
        quot_bits[i] = 1'b1;
        r = ritoa_pkg::RadixW'(trial - {1'b0, radix_q});
      end else begin
        r = trial[ritoa_pkg::RadixW-1:0];
      end
    end
    rem_next  = r;
    quot_next = (work_q << ritoa_pkg::STEP_BITS) | ritoa_pkg::WORK_W'(quot_bits);
  end

  assign last_chunk = (chunk_q == ritoa_pkg::CHUNK_W'(ritoa_pkg::NUM_CHUNKS - 1));
  assign div_done   = last_chunk &&
                      ((quot_next == '0) ||
                       (found_q == ritoa_pkg::FOUND_W'(ritoa_pkg::MAX_DIGITS - 1)));

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ritoa_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = ritoa_pkg::ST_DIV;
        end
      end
      ritoa_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = ritoa_pkg::ST_FETCH;
        end
      end
      ritoa_pkg::ST_FETCH: begin
        state_d = ritoa_pkg::ST_EMIT;
      end
      ritoa_pkg::ST_EMIT: begin
        if (out_fire && (idx_q == '0)) begin
          state_d = ritoa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ritoa_pkg::ST_IDLE;
      end
    endcase
  end

  // Handshake and RAM controls decoded from the state.
  always_comb begin
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    ram_we      = 1'b0;
    case (state_q)
      ritoa_pkg::ST_IDLE:  in_i.ready  = 1'b1;
      ritoa_pkg::ST_DIV:   ram_we      = last_chunk;
      ritoa_pkg::ST_FETCH: out_o.valid = 1'b0;
      ritoa_pkg::ST_EMIT:  out_o.valid = 1'b1;
      default:             in_i.ready  = 1'b0;
    endcase
  end

  // Datapath next values.
  always_comb begin
    work_d  = work_q;
    radix_d = radix_q;
    rem_d   = rem_q;
    chunk_d = chunk_q;
    found_d = found_q;
    idx_d   = idx_q;
    case (state_q)
      ritoa_pkg::ST_IDLE: begin
        if (in_fire) begin
          work_d  = ritoa_pkg::WORK_W'(in_i.value[ritoa_pkg::VALUE_BITS-1:0]);
          radix_d = ritoa_pkg::clamp_radix(in_i.radix);
          rem_d   = '0;
          chunk_d = '0;
          found_d = '0;
        end
      end
      ritoa_pkg::ST_DIV: begin
        work_d = quot_next;
        if (last_chunk) begin
          rem_d   = '0;
          chunk_d = '0;
          found_d = found_q + 1'b1;
          idx_d   = found_q[ritoa_pkg::IDX_W-1:0];
        end else begin
          rem_d   = rem_next;
          chunk_d = chunk_q + 1'b1;
        end
      end
      ritoa_pkg::ST_EMIT: begin
        if (out_fire && (idx_q != '0)) begin
          idx_d = idx_q - 1'b1;
        end
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ritoa_pkg::ST_IDLE;
      chunk_q <= '0;
      found_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      chunk_q <= chunk_d;
      found_q <= found_d;
      idx_q   <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    radix_q <= radix_d;
    rem_q   <= rem_d;
  end

  // Digit store: remainders written least significant first, read back in reverse.
  ritoa_ram #(
    .WIDTH (ritoa_pkg::RadixW),
    .DEPTH (ritoa_pkg::MAX_DIGITS)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (found_q[ritoa_pkg::IDX_W-1:0]),
    .wdata_i (rem_next),
    .raddr_i (idx_d),
    .rdata_o (ram_rdata)
  );

  // Result item.
  assign out_o.digit_char  = ritoa_pkg::digit_to_ascii(ram_rdata);
  assign out_o.digit_count = ritoa_pkg::CountW'(found_q);
  assign out_o.last_digit  = (idx_q == '0);

  // Every digit read back lies below the radix it was produced with.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (ram_rdata < radix_q))
    else $error("digit read back is not below the radix");

  // The digit count never exceeds the store depth and is nonzero while emitting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((found_q != '0) &&
                     (found_q <= ritoa_pkg::FOUND_W'(ritoa_pkg::MAX_DIGITS))))
    else $error("digit count out of range during emission");

  // Taking the last digit returns the block to accepting a new item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_o.last_digit) |=> in_i.ready)
    else $error("block not ready after the last digit");

  // An accepted item always starts a division pass at chunk zero with no digits found yet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ((state_q == ritoa_pkg::ST_DIV) && (chunk_q == '0) && (found_q == '0)))
    else $error("division pass did not start cleanly");

endmodule

@@ tb/sv/ritoa_checker.sv @@
// Checker for the radix converter: watches both channels, predicts the digits and compares.
`timescale 1ns / 100ps

module ritoa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ritoa_in_if         in_i,
  ritoa_out_if        out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  import ritoa_pkg::*;

  typedef struct {
    char_t  digit_char;
    count_t digit_count;
    logic   last_digit;
  } digit_item_t;

  // Digits still owed by the block, oldest first.
  digit_item_t digits_due[$];

  // Convert one value and queue its digits, most significant first.
  function automatic void queue_digits(value_t raw_value, radix_t raw_radix);
    value_t      keep_mask;
    value_t      quotient;
    int unsigned base;
    int unsigned n;
    logic [5:0]  rems [MAX_DIGITS];
    digit_item_t d;
    keep_mask = {ValueW{1'b1}} >> (ValueW - VALUE_BITS);
    quotient  = raw_value & keep_mask;
    // Out-of-range bases are pulled to the nearest legal one.
    base = raw_radix;
    if (base < RADIX_MIN) begin
      base = RADIX_MIN;
    end
    if (base > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    // Collect remainders, least significant first; zero still yields one digit.
    n = 0;
    do begin
      rems[n]  = 6'(quotient % base);
      n        = n + 1;
      quotient = quotient / base;
    end while (quotient != 0 && n < MAX_DIGITS);
    // Emit in reverse order.
    for (int k = n - 1; k >= 0; k--) begin
      if (rems[k] < 6'd10) begin
        d.digit_char = CHAR_ZERO + char_t'(rems[k]);
      end else begin
        d.digit_char = CHAR_LETTER_A + char_t'(rems[k] - 6'd10);
      end
      d.digit_count = count_t'(n);
      d.last_digit  = (k == 0);
      digits_due.push_back(d);
    end
  endfunction

  // Compare accepted digits, then record newly accepted conversions.
  always @(posedge clk_i or negedge rst_ni) begin
    digit_item_t want;
    logic        bad;
    if (!rst_ni) begin
      digits_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (digits_due.size() == 0) begin
          $error("unexpected digit item: digit_char %0d digit_count %0d last_digit %0d",
                 out_i.digit_char, out_i.digit_count, out_i.last_digit);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = digits_due.pop_front();
          bad  = 1'b0;
          if (out_i.digit_char !== want.digit_char) begin
            $error("digit_char mismatch: expected %0d, got %0d",
                   want.digit_char, out_i.digit_char);
            bad = 1'b1;
          end
          if (out_i.digit_count !== want.digit_count) begin
            $error("digit_count mismatch: expected %0d, got %0d",
                   want.digit_count, out_i.digit_count);
            bad = 1'b1;
          end
          if (out_i.last_digit !== want.last_digit) begin
            $error("last_digit mismatch: expected %0d, got %0d",
                   want.last_digit, out_i.last_digit);
            bad = 1'b1;
          end
          // One failure is counted per mismatching item.
          if (bad) begin
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        queue_digits(in_i.value, in_i.radix);
      end
      pending_o <= digits_due.size();
    end
  end

endmodule

@@ tb/sv/tb_radix_integer_to_ascii_unit.sv @@
// Testbench top for the radix converter: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module tb_radix_integer_to_ascii_unit;

  import ritoa_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        quiet_phase;
  int unsigned stall_left;
  int unsigned fail_count;
  int unsigned pending;

  ritoa_in_if  in_ch ();
  ritoa_out_if out_ch ();

  radix_integer_to_ascii_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  ritoa_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Output back-pressure: random stalls, none started during quiet phases.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= idle_cycles();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Offer one conversion and return at the edge that accepts it. Valid stays high
  // afterwards so that a back-to-back item needs no second assignment in one step.
  task automatic send_conversion(input value_t v, input radix_t r);
    int unsigned gap;
    gap = quiet_phase ? 0 : idle_cycles();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.radix <= r;
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Random value whose digit count spreads over the whole range.
  function automatic value_t random_value();
    int unsigned shape;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      return value_t'($urandom_range(0, 40));
    end else if (shape == 1) begin
      return ~value_t'(0) >> $urandom_range(0, 3);
    end
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  // Mostly legal bases, sometimes any 6-bit code.
  function automatic radix_t random_radix();
    if ($urandom_range(0, 9) == 0) begin
      return radix_t'($urandom_range(0, 63));
    end
    return radix_t'($urandom_range(RADIX_MIN, RADIX_MAX));
  endfunction

  // Stimulus and verdict.
  initial begin
    quiet_phase  = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    in_ch.radix  = RADIX_MIN;
    out_ch.ready = 1'b0;
    rst_ni       = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero, extremes of value and base, letter boundaries and clamped bases.
    send_conversion(64'd0, 6'd10);
    send_conversion(64'd0, 6'd2);
    send_conversion(64'hFFFF_FFFF_FFFF_FFFF, 6'd2);
    send_conversion(64'hFFFF_FFFF_FFFF_FFFF, 6'd36);
    send_conversion(64'hFFFF_FFFF_FFFF_FFFF, 6'd16);
    send_conversion(64'hFFFF_FFFF_FFFF_FFFF, 6'd10);
    send_conversion(64'hFFFF_FFFF_FFFF_FFFF, 6'd3);
    send_conversion(64'h8000_0000_0000_0000, 6'd36);
    send_conversion(64'hFEDC_BA98_7654_3210, 6'd16);
    send_conversion(64'd1, 6'd2);
    send_conversion(64'd9, 6'd10);
    send_conversion(64'd10, 6'd11);
    send_conversion(64'd35, 6'd36);
    send_conversion(64'd36, 6'd36);
    send_conversion(64'd1295, 6'd36);
    send_conversion(64'd255, 6'd15);
    // Bases below two act as binary.
    send_conversion(64'd5, 6'd0);
    send_conversion(64'd6, 6'd1);
    // Bases above thirty-six act as base 36.
    send_conversion(64'd35, 6'd37);
    send_conversion(64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
    send_conversion(64'h5555_5555_5555_5555, 6'd48);

    // Random conversions in blocks; one block runs without any idling.
    for (int blk = 0; blk < 5; blk++) begin
      quiet_phase = (blk == 2);
      for (int n = 0; n < 44; n++) begin
        send_conversion(random_value(), random_radix());
      end
    end
    in_ch.valid <= 1'b0;
    quiet_phase = 1'b0;

    // Drain, then keep watching for stray digits before the verdict.
    do @(negedge clk_i); while (pending != 0);
    repeat (32) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ritoa_pkg.sv
rtl/ritoa_in_if.sv
rtl/ritoa_out_if.sv
rtl/ritoa_ram.sv
rtl/radix_integer_to_ascii_unit.sv
tb/sv/ritoa_checker.sv
tb/sv/tb_radix_integer_to_ascii_unit.sv
